### sv/gfc_pkg.sv
// Shared constants, codes and types of the GIF frame compositor.
// Depends on nothing; every other file of the block uses it by scoped names.
package gfc_pkg;

  localparam int MAX_WIDTH_DEF     = 256;
  localparam int MAX_HEIGHT_DEF    = 256;
  localparam int PALETTE_DEPTH_DEF = 256;

  localparam int CFG_INDEX_W = 4;

  typedef enum logic [1:0] {
    OP_PALETTE = 2'd0,
    OP_FRAME   = 2'd1,
    OP_PIXEL   = 2'd2,
    OP_READ    = 2'd3
  } opcode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CANVAS_WIDTH  = 4'd0,
    REG_CANVAS_HEIGHT = 4'd1,
    REG_BG_ENABLE     = 4'd2,
    REG_BG_ARGB       = 4'd3
  } cfg_reg_t;

  localparam logic [2:0]  DISPOSAL_BACKGROUND = 3'd2;
  localparam logic [7:0]  OPAQUE_ALPHA        = 8'hFF;
  localparam logic [31:0] CLEAR_WORD          = 32'h0000_0000;

  localparam logic [8:0] CANVAS_WIDTH_RST  = 9'd256;
  localparam logic [8:0] CANVAS_HEIGHT_RST = 9'd256;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_FILL
  } state_t;

endpackage

### sv/gfc_if.sv
// Handshake channels of the GIF frame compositor: requests, results and
// configuration writes. Depends on gfc_pkg for the configuration index width.
interface gfc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  index;
  logic [23:0] rgb;
  logic [15:0] x_pos;
  logic [15:0] y_pos;
  logic [15:0] span_width;
  logic [15:0] span_height;
  logic [2:0]  disposal;
  logic        transparent_enable;
  logic [8:0]  color_count;

  modport source (output valid, opcode, index, rgb, x_pos, y_pos, span_width, span_height,
                  disposal, transparent_enable, color_count, input ready);
  modport sink   (input valid, opcode, index, rgb, x_pos, y_pos, span_width, span_height,
                  disposal, transparent_enable, color_count, output ready);
endinterface

interface gfc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_argb;

  modport source (output valid, pixel_argb, input ready);
  modport sink   (input valid, pixel_argb, output ready);
endinterface

interface gfc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gfc_pkg::CFG_INDEX_W-1:0] index;
  logic [31:0]                     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/gfc_canvas.sv
// Canvas word memory: one write port and one registered read port.
// A read of the entry written in the same cycle returns the new word.
module gfc_canvas #(
  parameter int DEPTH = gfc_pkg::MAX_WIDTH_DEF * gfc_pkg::MAX_HEIGHT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_q
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_q <= wr_data;
      end else begin
        rd_q <= mem[rd_addr];
      end
    end
  end

endmodule

### sv/gif_frame_compositor_unit.sv
// Top level of the GIF frame compositor: palette memory, frame registers,
// pixel and read pipeline, background fill and reset clearing sequencer.
// Depends on gfc_pkg, the channels in gfc_if and the gfc_canvas memory.
// While running, one request per cycle is accepted unless held off as below.
// A read result is registered by the canvas read port alongside the s1 stage and
// then loaded into the output register; a read that finds a result still
// waiting there holds off requests. A frame start with background disposal
// and a non-empty clipped rectangle holds off requests while the canvas write
// port fills that rectangle. After reset a clearing pass writes zero to all
// MAX_WIDTH*MAX_HEIGHT canvas words, one per cycle (65536 at defaults), before
// any request is taken.
module gif_frame_compositor_unit #(
  parameter int MAX_WIDTH     = gfc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = gfc_pkg::MAX_HEIGHT_DEF,
  parameter int PALETTE_DEPTH = gfc_pkg::PALETTE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gfc_req_if.sink    req,
  gfc_rsp_if.source  rsp,
  gfc_cfg_if.sink    cfg
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int EW    = $clog2(MAX_WIDTH + 1);
  localparam int EH    = $clog2(MAX_HEIGHT + 1);
  localparam int PIW   = $clog2(PALETTE_DEPTH);

  gfc_pkg::state_t state, state_next;

  logic [8:0]  canvas_width, canvas_height;
  logic        background_enable;
  logic [31:0] background_argb;

  logic [15:0] frame_left, frame_top, frame_cols, frame_rows;
  logic        transparency_on;
  logic [7:0]  clear_index;
  logic [8:0]  palette_count;
  logic [15:0] col_counter, row_counter;

  logic [AW-1:0] clr_addr;
  logic [XW-1:0] fill_x, fill_x0;
  logic [YW-1:0] fill_y;
  logic [EW-1:0] fill_xe;
  logic [EH-1:0] fill_ye;

  logic          s1_valid, s1_rd, s1_wr, s1_pal, s1_zero;
  logic [XW-1:0] s1_x;
  logic [YW-1:0] s1_y;

  logic        out_valid;
  logic [31:0] out_data;

  logic [23:0] palette_mem [PALETTE_DEPTH];
  logic [23:0] pal_q;

  logic [EW-1:0] effw;
  logic [EH-1:0] effh;
  logic [31:0]   bg_word;
  logic          accept, s1_adv, clr_last, fill_last;
  logic          is_pal, is_frame, is_pixel, is_read;
  logic          idx_in_pal;

  logic [16:0]   px_cx, px_cy;
  logic          px_active, px_wr, px_use_pal;
  logic [16:0]   col_inc;

  logic [16:0]   fr_xsum, fr_ysum;
  logic          fill_go;
  logic [EW-1:0] fr_xe;
  logic [EH-1:0] fr_ye;

  logic          rd_inside, rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_q;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [XW-1:0] wr_x;
  logic [YW-1:0] wr_y;

  assign effw = (17'(canvas_width) > 17'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(canvas_width);
  assign effh = (17'(canvas_height) > 17'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT) : EH'(canvas_height);
  assign bg_word = background_enable ? background_argb : gfc_pkg::CLEAR_WORD;

  assign is_pal   = (req.opcode == gfc_pkg::OP_PALETTE);
  assign is_frame = (req.opcode == gfc_pkg::OP_FRAME);
  assign is_pixel = (req.opcode == gfc_pkg::OP_PIXEL);
  assign is_read  = (req.opcode == gfc_pkg::OP_READ);

  assign accept = req.valid && req.ready;
  assign s1_adv = !(s1_valid && s1_rd && out_valid && !rsp.ready);
  assign idx_in_pal = (9'(req.index) < 9'(PALETTE_DEPTH));

  // Pixel position and decision for the request being accepted.
  assign px_active  = (frame_cols != 16'd0) && (row_counter < frame_rows);
  assign px_cx      = 17'(frame_left) + 17'(col_counter);
  assign px_cy      = 17'(frame_top) + 17'(row_counter);
  assign px_wr      = px_active && !(transparency_on && (req.index == clear_index)) &&
                      (px_cx < 17'(effw)) && (px_cy < 17'(effh));
  assign px_use_pal = (9'(req.index) < palette_count) && idx_in_pal;
  assign col_inc    = 17'(col_counter) + 17'd1;

  // Clipped rectangle of a background fill.
  assign fr_xsum = 17'(req.x_pos) + 17'(req.span_width);
  assign fr_ysum = 17'(req.y_pos) + 17'(req.span_height);
  assign fr_xe   = (fr_xsum < 17'(effw)) ? EW'(fr_xsum) : effw;
  assign fr_ye   = (fr_ysum < 17'(effh)) ? EH'(fr_ysum) : effh;
  assign fill_go = (req.disposal == gfc_pkg::DISPOSAL_BACKGROUND) &&
                   (req.span_width != 16'd0) && (req.span_height != 16'd0) &&
                   (17'(req.x_pos) < 17'(effw)) && (17'(req.y_pos) < 17'(effh));

  assign rd_inside = (17'(req.x_pos) < 17'(effw)) && (17'(req.y_pos) < 17'(effh));
  assign rd_en     = accept && is_read && rd_inside;
  assign rd_addr   = AW'(req.y_pos[YW-1:0]) * AW'(MAX_WIDTH) + AW'(req.x_pos[XW-1:0]);

  assign clr_last  = (clr_addr == AW'(DEPTH - 1));
  assign fill_last = ((EW'(fill_x) + EW'(1)) == fill_xe) &&
                     ((EH'(fill_y) + EH'(1)) == fill_ye);

  always_comb begin
    state_next = state;
    unique case (state)
      gfc_pkg::ST_CLEAR: begin
        if (clr_last) state_next = gfc_pkg::ST_RUN;
      end
      gfc_pkg::ST_RUN: begin
        if (accept && is_frame && fill_go) state_next = gfc_pkg::ST_FILL;
      end
      gfc_pkg::ST_FILL: begin
        if (fill_last) state_next = gfc_pkg::ST_RUN;
      end
      default: state_next = gfc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    wr_x      = s1_x;
    wr_y      = s1_y;
    wr_en     = 1'b0;
    wr_data   = s1_pal ? {gfc_pkg::OPAQUE_ALPHA, pal_q} : bg_word;
    unique case (state)
      gfc_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = gfc_pkg::CLEAR_WORD;
      end
      gfc_pkg::ST_RUN: begin
        req.ready = s1_adv;
        wr_en     = s1_wr;
      end
      gfc_pkg::ST_FILL: begin
        wr_en   = 1'b1;
        wr_x    = fill_x;
        wr_y    = fill_y;
        wr_data = bg_word;
      end
      default: wr_en = 1'b0;
    endcase
    wr_addr = (state == gfc_pkg::ST_CLEAR) ? clr_addr :
              AW'(wr_y) * AW'(MAX_WIDTH) + AW'(wr_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gfc_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == gfc_pkg::ST_CLEAR) clr_addr <= clr_addr + AW'(1);
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width      <= gfc_pkg::CANVAS_WIDTH_RST;
      canvas_height     <= gfc_pkg::CANVAS_HEIGHT_RST;
      background_enable <= 1'b0;
      background_argb   <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        gfc_pkg::REG_CANVAS_WIDTH:  canvas_width      <= cfg.data[8:0];
        gfc_pkg::REG_CANVAS_HEIGHT: canvas_height     <= cfg.data[8:0];
        gfc_pkg::REG_BG_ENABLE:     background_enable <= cfg.data[0];
        gfc_pkg::REG_BG_ARGB:       background_argb   <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_left      <= '0;
      frame_top       <= '0;
      frame_cols      <= '0;
      frame_rows      <= '0;
      transparency_on <= 1'b0;
      clear_index     <= '0;
      palette_count   <= '0;
      col_counter     <= '0;
      row_counter     <= '0;
    end else if (accept && is_frame) begin
      frame_left      <= req.x_pos;
      frame_top       <= req.y_pos;
      frame_cols      <= req.span_width;
      frame_rows      <= req.span_height;
      transparency_on <= req.transparent_enable;
      clear_index     <= req.index;
      palette_count   <= req.color_count;
      col_counter     <= '0;
      row_counter     <= '0;
    end else if (accept && is_pixel && px_active) begin
      if (col_inc >= 17'(frame_cols)) begin
        col_counter <= '0;
        row_counter <= row_counter + 16'd1;
      end else begin
        col_counter <= col_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_frame) begin
      fill_x  <= req.x_pos[XW-1:0];
      fill_x0 <= req.x_pos[XW-1:0];
      fill_y  <= req.y_pos[YW-1:0];
      fill_xe <= fr_xe;
      fill_ye <= fr_ye;
    end else if (state == gfc_pkg::ST_FILL) begin
      if ((EW'(fill_x) + EW'(1)) == fill_xe) begin
        fill_x <= fill_x0;
        fill_y <= fill_y + YW'(1);
      end else begin
        fill_x <= fill_x + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_pal && idx_in_pal) begin
      palette_mem[req.index[PIW-1:0]] <= req.rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_pixel && idx_in_pal) begin
      pal_q <= palette_mem[req.index[PIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_rd    <= 1'b0;
      s1_wr    <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= accept;
      s1_rd    <= accept && is_read;
      s1_wr    <= accept && is_pixel && px_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_pal  <= px_use_pal;
      s1_zero <= !rd_inside;
      s1_x    <= px_cx[XW-1:0];
      s1_y    <= px_cy[YW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_rd && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_rd && (!out_valid || rsp.ready)) begin
      out_data <= s1_zero ? gfc_pkg::CLEAR_WORD : rd_q;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.pixel_argb = out_data;

  gfc_canvas #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_canvas (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_q    (rd_q)
  );

  a_no_request_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != gfc_pkg::ST_RUN) |-> !req.ready)
    else $error("request taken during clearing or fill");

  a_read_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_rd && out_valid && !rsp.ready) |=> (s1_valid && s1_rd))
    else $error("stalled read lost before reaching output register");

  a_clear_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (state == gfc_pkg::ST_CLEAR))
    else $error("clearing pass not started after reset");

  a_fill_owns_write_port: assert property (@(posedge clk) disable iff (rst)
    (state == gfc_pkg::ST_FILL) |-> !s1_wr)
    else $error("pixel write collides with background fill");

endmodule

### tb/gfc_canvas_tracker.sv
// Canvas tracker for the GIF frame compositor: follows requests, configuration
// writes and read results, keeps its own canvas and palette, and checks each word.
// Depends on gfc_pkg and the channel interfaces in gfc_if.
module gfc_canvas_tracker
  import gfc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  gfc_req_if   req,
  gfc_rsp_if   rsp,
  gfc_cfg_if   cfg,
  output int   mismatch_count,
  output int   pending_reads
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CANVAS_WORDS = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  logic [31:0] canvas_mem [CANVAS_WORDS];
  logic [23:0] palette_mem [PALETTE_DEPTH_DEF];

  logic [8:0]  canvas_w;
  logic [8:0]  canvas_h;
  logic        bg_on;
  logic [31:0] bg_argb;

  logic [15:0] frame_x;
  logic [15:0] frame_y;
  logic [15:0] frame_cols;
  logic [15:0] frame_rows;
  logic        trans_on;
  logic [7:0]  trans_index;
  logic [8:0]  color_limit;
  logic [15:0] col_pos;
  logic [15:0] row_pos;

  logic [31:0] expected_argb [$];
  int          errors = 0;

  function automatic int clip_w();
    return (canvas_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(canvas_w);
  endfunction

  function automatic int clip_h();
    return (canvas_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(canvas_h);
  endfunction

  function automatic logic [31:0] background();
    return bg_on ? bg_argb : CLEAR_WORD;
  endfunction

  function automatic bit on_canvas(int x, int y);
    return (x < clip_w()) && (y < clip_h());
  endfunction

  task automatic store_word(int x, int y, logic [31:0] word);
    if (on_canvas(x, y)) begin
      canvas_mem[y * MAX_WIDTH_DEF + x] = word;
    end
  endtask

  task automatic apply_request();
    int          r;
    int          c;
    int          fx;
    int          fy;
    logic [31:0] word;
    case (req.opcode)
      OP_PALETTE: begin
        if (int'(req.index) < PALETTE_DEPTH_DEF) begin
          palette_mem[req.index] = req.rgb;
        end
      end
      OP_FRAME: begin
        frame_x     = req.x_pos;
        frame_y     = req.y_pos;
        frame_cols  = req.span_width;
        frame_rows  = req.span_height;
        trans_on    = req.transparent_enable;
        trans_index = req.index;
        color_limit = req.color_count;
        col_pos     = '0;
        row_pos     = '0;
        if (req.disposal == DISPOSAL_BACKGROUND) begin
          word = background();
          fx   = int'(frame_x);
          fy   = int'(frame_y);
          for (r = 0; r < int'(frame_rows) && fy + r < clip_h(); r++) begin
            for (c = 0; c < int'(frame_cols) && fx + c < clip_w(); c++) begin
              store_word(fx + c, fy + r, word);
            end
          end
        end
      end
      OP_PIXEL: begin
        if (frame_cols != 0 && row_pos < frame_rows) begin
          if (!(trans_on && req.index == trans_index)) begin
            if (req.index < color_limit && int'(req.index) < PALETTE_DEPTH_DEF) begin
              word = {OPAQUE_ALPHA, palette_mem[req.index]};
            end else begin
              word = background();
            end
            store_word(int'(frame_x) + int'(col_pos), int'(frame_y) + int'(row_pos), word);
          end
          col_pos = col_pos + 16'd1;
          if (col_pos >= frame_cols) begin
            col_pos = '0;
            row_pos = row_pos + 16'd1;
          end
        end
      end
      OP_READ: begin
        word = CLEAR_WORD;
        if (on_canvas(int'(req.x_pos), int'(req.y_pos))) begin
          word = canvas_mem[int'(req.y_pos) * MAX_WIDTH_DEF + int'(req.x_pos)];
        end
        expected_argb = {expected_argb, word};
      end
      default: ;
    endcase
  endtask

  task automatic check_response();
    logic [31:0] want;
    if (expected_argb.size() == 0) begin
      $error("pixel_argb: result with no read outstanding, actual %h", rsp.pixel_argb);
      errors++;
    end else begin
      want = expected_argb.pop_front();
      if (rsp.pixel_argb !== want) begin
        $error("pixel_argb: expected %h, actual %h", want, rsp.pixel_argb);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (canvas_mem[i]) canvas_mem[i] = CLEAR_WORD;
      foreach (palette_mem[i]) palette_mem[i] = '0;
      canvas_w    = CANVAS_WIDTH_RST;
      canvas_h    = CANVAS_HEIGHT_RST;
      bg_on       = 1'b0;
      bg_argb     = CLEAR_WORD;
      frame_x     = '0;
      frame_y     = '0;
      frame_cols  = '0;
      frame_rows  = '0;
      trans_on    = 1'b0;
      trans_index = '0;
      color_limit = '0;
      col_pos     = '0;
      row_pos     = '0;
      expected_argb.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_CANVAS_WIDTH:  canvas_w = cfg.data[8:0];
          REG_CANVAS_HEIGHT: canvas_h = cfg.data[8:0];
          REG_BG_ENABLE:     bg_on    = cfg.data[0];
          REG_BG_ARGB:       bg_argb  = cfg.data;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        check_response();
      end
      if (req.valid && req.ready) begin
        apply_request();
      end
    end
    mismatch_count <= errors;
    pending_reads  <= expected_argb.size();
  end

endmodule

### tb/gif_frame_compositor_unit_tb.sv
// Top of the GIF frame compositor testbench: clock, reset, configuration phases,
// directed and random request traffic, result stalls and the verdict.
// Depends on gfc_pkg, gfc_if, the compositor RTL and gfc_canvas_tracker.
module gif_frame_compositor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gfc_pkg::*;

  localparam int RESET_CYCLES  = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 85;

  localparam logic [2:0] DISPOSAL_NONE     = 3'd0;
  localparam logic [2:0] DISPOSAL_PREVIOUS = 3'd3;
  localparam logic [2:0] DISPOSAL_RESERVED = 3'd7;

  typedef struct packed {
    opcode_t     op;
    logic [7:0]  index;
    logic [23:0] rgb;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [15:0] span_width;
    logic [15:0] span_height;
    logic [2:0]  disposal;
    logic        transparent_enable;
    logic [8:0]  color_count;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gfc_req_if req_ch ();
  gfc_rsp_if rsp_ch ();
  gfc_cfg_if cfg_ch ();

  int         failures;
  int         outstanding;
  int         cycle_count   = 0;
  int         items_sent    = 0;
  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  int         hold_requests = 0;
  int         holds_started = 0;
  int         hold_left     = 0;
  bit         palette_known [256];
  int         frame_colors  = 0;
  bit         frame_trans   = 1'b0;
  logic [7:0] frame_clear   = '0;
  int         view_w        = 256;
  int         view_h        = 256;

  always #4 clk = ~clk;

  gif_frame_compositor_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  gfc_canvas_tracker u_tracker (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .cfg            (cfg_ch),
    .mismatch_count (failures),
    .pending_reads  (outstanding)
  );

  always @(posedge clk) begin
    if (holds_started != hold_requests) begin
      holds_started = hold_requests;
      hold_left     = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** gif_frame_compositor_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_request(request_t rq);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req_ch.valid              <= 1'b1;
    req_ch.opcode             <= rq.op;
    req_ch.index              <= rq.index;
    req_ch.rgb                <= rq.rgb;
    req_ch.x_pos              <= rq.x_pos;
    req_ch.y_pos              <= rq.y_pos;
    req_ch.span_width         <= rq.span_width;
    req_ch.span_height        <= rq.span_height;
    req_ch.disposal           <= rq.disposal;
    req_ch.transparent_enable <= rq.transparent_enable;
    req_ch.color_count        <= rq.color_count;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_palette(logic [7:0] slot, logic [23:0] color);
    request_t rq;
    rq       = '0;
    rq.op    = OP_PALETTE;
    rq.index = slot;
    rq.rgb   = color;
    palette_known[slot] = 1'b1;
    send_request(rq);
  endtask

  task automatic start_frame(int x, int y, int w, int h, logic [2:0] disp, bit trans,
                             logic [7:0] clear, int colors);
    request_t rq;
    rq                    = '0;
    rq.op                 = OP_FRAME;
    rq.x_pos              = 16'(x);
    rq.y_pos              = 16'(y);
    rq.span_width         = 16'(w);
    rq.span_height        = 16'(h);
    rq.disposal           = disp;
    rq.transparent_enable = trans;
    rq.index              = clear;
    rq.color_count        = 9'(colors);
    frame_colors = colors;
    frame_trans  = trans;
    frame_clear  = clear;
    send_request(rq);
  endtask

  // A pixel that would use a palette slot never loaded gets the slot loaded first.
  task automatic put_pixel(logic [7:0] idx);
    request_t rq;
    if (int'(idx) < frame_colors && !(frame_trans && idx == frame_clear) &&
        !palette_known[idx]) begin
      load_palette(idx, 24'($urandom));
    end
    rq       = '0;
    rq.op    = OP_PIXEL;
    rq.index = idx;
    send_request(rq);
  endtask

  task automatic read_canvas(int x, int y);
    request_t rq;
    rq       = '0;
    rq.op    = OP_READ;
    rq.x_pos = 16'(x);
    rq.y_pos = 16'(y);
    send_request(rq);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(int w, int h, bit bg_en, logic [31:0] bg);
    write_reg(REG_CANVAS_WIDTH, 32'(w));
    write_reg(REG_CANVAS_HEIGHT, 32'(h));
    write_reg(REG_BG_ENABLE, 32'(bg_en));
    write_reg(REG_BG_ARGB, bg);
    view_w = (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
    view_h = (h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h;
  endtask

  task automatic quiesce();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || !req_ch.ready) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic directed_cases();
    put_pixel(8'd5);
    read_canvas(0, 0);
    load_palette(8'd0, 24'h000000);
    load_palette(8'd255, 24'hFFFFFF);
    load_palette(8'd1, 24'hA5C3E1);
    start_frame(0, 0, 65535, 65535, DISPOSAL_BACKGROUND, 1'b0, 8'd0, 256);
    read_canvas(255, 255);
    read_canvas(65535, 65535);
    read_canvas(256, 0);
    start_frame(254, 254, 4, 4, DISPOSAL_BACKGROUND, 1'b1, 8'd1, 256);
    put_pixel(8'd0);
    put_pixel(8'd1);
    put_pixel(8'd255);
    put_pixel(8'd1);
    put_pixel(8'd255);
    put_pixel(8'd0);
    put_pixel(8'd1);
    read_canvas(254, 254);
    read_canvas(255, 254);
    read_canvas(254, 255);
    start_frame(3, 3, 2, 1, DISPOSAL_PREVIOUS, 1'b0, 8'd0, 0);
    put_pixel(8'd0);
    put_pixel(8'd255);
    put_pixel(8'd0);
    read_canvas(3, 3);
    read_canvas(4, 3);
    start_frame(10, 10, 0, 5, DISPOSAL_RESERVED, 1'b0, 8'd0, 1);
    put_pixel(8'd0);
    read_canvas(10, 10);
  endtask

  task automatic well_formed_frame();
    int         w;
    int         h;
    int         x;
    int         y;
    int         colors;
    int         npx;
    int         sel;
    bit         trans;
    logic [7:0] clear;
    logic [7:0] idx;
    w      = $urandom_range(10, 1);
    h      = $urandom_range(5, 1);
    x      = $urandom_range(view_w + 1);
    y      = $urandom_range(view_h + 1);
    sel    = $urandom_range(9);
    colors = (sel < 3) ? 256 : (sel < 4) ? 0 : $urandom_range(256, 1);
    trans  = 1'($urandom_range(1));
    clear  = 8'($urandom_range(255));
    start_frame(x, y, w, h, 3'($urandom_range(7)), trans, clear, colors);
    npx = w * h + (($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0);
    repeat (npx) begin
      sel = $urandom_range(3);
      case (sel)
        0: idx = clear;
        1: idx = 8'($urandom_range(255));
        2: idx = 8'((colors > 255) ? 255 : colors - 1 + $urandom_range(1));
        default: idx = 8'($urandom_range(15));
      endcase
      put_pixel(idx);
    end
    repeat ($urandom_range(4, 1)) begin
      read_canvas(x + $urandom_range(w), y + $urandom_range(h));
    end
  endtask

  task automatic read_sweep();
    repeat ($urandom_range(6, 2)) begin
      if ($urandom_range(9) < 7) begin
        read_canvas($urandom_range(view_w), $urandom_range(view_h));
      end else begin
        read_canvas($urandom_range(65535), $urandom_range(65535));
      end
    end
  endtask

  task automatic palette_sweep();
    repeat ($urandom_range(4, 1)) begin
      load_palette(8'($urandom_range(255)), 24'($urandom));
    end
  endtask

  // Wide spans are kept off the background fill unless the clipped area is modest.
  task automatic noise_frame();
    int         x;
    int         y;
    int         w;
    int         h;
    int         cols;
    int         rows;
    logic [2:0] disp;
    x    = ($urandom_range(1) == 0) ? $urandom_range(65535) : $urandom_range(view_w);
    y    = ($urandom_range(1) == 0) ? $urandom_range(65535) : $urandom_range(view_h);
    w    = $urandom_range(65535);
    h    = $urandom_range(65535);
    disp = 3'($urandom_range(7));
    cols = (x < view_w) ? ((w < view_w - x) ? w : view_w - x) : 0;
    rows = (y < view_h) ? ((h < view_h - y) ? h : view_h - y) : 0;
    if (disp == DISPOSAL_BACKGROUND && cols * rows > 1024) begin
      disp = DISPOSAL_NONE;
    end
    start_frame(x, y, w, h, disp, 1'($urandom_range(1)), 8'($urandom_range(255)),
                $urandom_range(256));
    repeat ($urandom_range(6)) put_pixel(8'($urandom_range(255)));
  endtask

  task automatic mixed_traffic(int budget);
    int stop_at;
    int pick;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        well_formed_frame();
      end else if (pick < 75) begin
        read_sweep();
      end else if (pick < 85) begin
        palette_sweep();
      end else begin
        noise_frame();
      end
    end
  endtask

  initial begin
    req_ch.valid              = 1'b0;
    req_ch.opcode             = '0;
    req_ch.index              = '0;
    req_ch.rgb                = '0;
    req_ch.x_pos              = '0;
    req_ch.y_pos              = '0;
    req_ch.span_width         = '0;
    req_ch.span_height        = '0;
    req_ch.disposal           = '0;
    req_ch.transparent_enable = 1'b0;
    req_ch.color_count        = '0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.index              = '0;
    cfg_ch.data               = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    quiesce();
    apply_setting(256, 256, 1'b1, 32'h80A0_B0C0);
    directed_cases();
    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      case (p)
        0: apply_setting(256, 256, 1'b1, $urandom);
        1: apply_setting(1, 1, 1'b0, $urandom);
        2: apply_setting(17, 9, 1'b1, 32'hFFFF_FFFF);
        3: apply_setting(256, 256, 1'b0, 32'h0000_0000);
        4: apply_setting(511, 300, 1'b1, $urandom);
        5: apply_setting(0, 40, 1'b1, $urandom);
        6: apply_setting(100, 256, 1'b1, $urandom);
        default: apply_setting(256, 1, 1'b1, $urandom);
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      if (p == 0) begin
        hold_requests++;
        repeat (40) read_canvas($urandom_range(255), $urandom_range(255));
        quiesce();
      end
      mixed_traffic(PHASE_ITEMS);
    end
    quiesce();
    if (failures == 0) begin
      $display("** gif_frame_compositor_unit: PASSED **");
    end else begin
      $display("** gif_frame_compositor_unit: FAILED **");
    end
    $finish;
  end

endmodule
